// ----- design/twrb_pkg.sv -----
// ----------------------------------------------------------------------------
// twrb_pkg
// Shared types and constants for the time window reorder buffer.
// ----------------------------------------------------------------------------
package twrb_pkg;

    localparam int CAPACITY = 32;

    localparam int TIME_W   = 40;
    localparam int KEY_W    = 32;
    localparam int TAG_W    = 16;
    localparam int EPOCH_W  = 22;
    localparam int DEPTH_W  = 8;
    localparam int WINDOW_W = EPOCH_W + DEPTH_W;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [EPOCH_W-1:0] EPOCH_RESET = EPOCH_W'(6000);
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(3);

    // register index, taken from paddr[2]
    localparam logic REG_EPOCH  = 1'b0;
    localparam logic REG_WINDOW = 1'b1;

    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        VERDICT_ORDER  = 2'd0,
        VERDICT_REJECT = 2'd1,
        VERDICT_DUP    = 2'd2
    } t_verdict;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT,
        CELL_POP
    } t_cell_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_RELEASE,
        S_DRAIN,
        S_FLUSH,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0] time_stamp;
        logic [KEY_W-1:0]  sort_key;
        logic [TAG_W-1:0]  message_tag;
    } t_item;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        t_cell_cmd cmd;
        t_item     item;
    } t_cell_ctrl;

    // what a cell shows its neighbors
    typedef struct packed {
        logic  valid;
        logic  lt;
        t_item item;
    } t_link;

endpackage

// ----- design/twrb_if.sv -----
// ----------------------------------------------------------------------------
// twrb request and result channels
// Valid/ready channels carrying one request in and one result out.
// ----------------------------------------------------------------------------
interface twrb_in_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [twrb_pkg::TIME_W-1:0]  time_stamp;
    logic [twrb_pkg::KEY_W-1:0]   sort_key;
    logic [twrb_pkg::TAG_W-1:0]   message_tag;
    logic                         batch_end;

    modport source (
        output valid, operation, time_stamp, sort_key, message_tag, batch_end,
        input  ready
    );
    modport sink (
        input  valid, operation, time_stamp, sort_key, message_tag, batch_end,
        output ready
    );
endinterface

interface twrb_out_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   verdict;
    logic [twrb_pkg::TIME_W-1:0]  out_time;
    logic [twrb_pkg::KEY_W-1:0]   out_key;
    logic [twrb_pkg::TAG_W-1:0]   out_tag;
    logic                         last_result;

    modport source (
        output valid, verdict, out_time, out_key, out_tag, last_result,
        input  ready
    );
    modport sink (
        input  valid, verdict, out_time, out_key, out_tag, last_result,
        output ready
    );
endinterface

// ----- design/time_window_reorder_buffer.sv -----
// ----------------------------------------------------------------------------
// time_window_reorder_buffer
// Orders timestamped messages by (time, key) in a chain of cells and
// releases them once they fall a window behind the newest one.
// ----------------------------------------------------------------------------
//  port     | dir | protocol       | content
//  i_req    | in  | valid/ready    | operation, time, key, tag, batch end
//  o_res    | out | valid/ready    | verdict, time, key, tag, last result
//  psel ... | in  | APB, no wait   | epoch_length @0x0, window_depth @0x4
//
// One request at a time: a push without batch end steps through accept,
// insert into the chain and finish; a push with batch end steps through
// accept, insert, release setup, drain check and finish, releasing messages
// in the drain check. A flush steps through accept, flush and finish and
// empties the store in the flush step. Releases leave through cell 0 at one
// per cycle while the result side takes them and pass a one-entry hold stage
// so the last flag is known before the result reaches the output register.
// Reset is synchronous, active low, and leaves the store empty. A stalled
// result side stops the sequencer only when a further result is due.
// ----------------------------------------------------------------------------
module time_window_reorder_buffer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    twrb_in_if.sink                       i_req,
    twrb_out_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [twrb_pkg::ADDR_W-1:0]   paddr,
    input  logic [twrb_pkg::DATA_W-1:0]   pwdata,
    output logic [twrb_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int CAP = twrb_pkg::CAPACITY;
    localparam int TW  = twrb_pkg::TIME_W;

    // configuration
    logic [twrb_pkg::EPOCH_W-1:0]  r_epoch;
    logic [twrb_pkg::DEPTH_W-1:0]  r_depth;
    logic [twrb_pkg::WINDOW_W-1:0] r_window;

    // sequencer state
    twrb_pkg::t_state   r_state;
    twrb_pkg::t_state   n_state;
    twrb_pkg::t_item    r_in_item;
    logic               r_in_be;
    logic               r_in_batch;
    logic               r_floor_active;
    logic [TW-1:0]      r_floor;
    logic [TW-1:0]      r_newest;
    logic [TW-1:0]      r_lim;
    logic               r_lim_ok;

    // hold stage and output register
    logic               r_pend_v;
    twrb_pkg::t_verdict r_pend_verdict;
    twrb_pkg::t_item    r_pend_item;
    logic               r_out_v;
    twrb_pkg::t_verdict r_out_verdict;
    twrb_pkg::t_item    r_out_item;
    logic               r_out_last;

    // chain
    twrb_pkg::t_cell_ctrl cell_ctrl;
    twrb_pkg::t_link      cell_link  [CAP];
    twrb_pkg::t_link      left_link  [CAP];
    twrb_pkg::t_link      right_link [CAP];
    logic [CAP-1:0]       cell_eq;
    twrb_pkg::t_link      head;

    // decode
    logic               accept;
    logic               cfg_write;
    logic               out_free;
    logic               can_emit;
    logic               empty;
    logic               full;
    logic               dup;
    logic               reject;
    logic               need_emit;
    logic               rel_ok;
    logic [TW:0]        diff;
    logic               diff_ok;
    logic               stored;

    // outputs of the sequencer
    logic               req_ready;
    twrb_pkg::t_cell_cmd cmd;
    logic               emit;
    twrb_pkg::t_verdict emit_verdict;
    twrb_pkg::t_item    emit_item;
    logic               pend_to_last;

    for (genvar gi = 0; gi < CAP; gi++) begin : g_cell
        if (gi == 0) begin : g_first
            assign left_link[gi] = '{valid: 1'b1, lt: 1'b0, item: '0};
        end else begin : g_mid_l
            assign left_link[gi] = cell_link[gi-1];
        end
        if (gi == CAP - 1) begin : g_last
            assign right_link[gi] = '{valid: 1'b0, lt: 1'b1, item: '0};
        end else begin : g_mid_r
            assign right_link[gi] = cell_link[gi+1];
        end

        twrb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (cell_ctrl),
            .i_left  (left_link[gi]),
            .i_right (right_link[gi]),
            .o_link  (cell_link[gi]),
            .o_eq    (cell_eq[gi])
        );
    end

    assign head      = cell_link[0];
    assign empty     = !head.valid;
    assign full      = cell_link[CAP-1].valid;
    assign dup       = |cell_eq;
    assign cell_ctrl = '{cmd: cmd, item: r_in_item};

    assign accept    = i_req.valid && req_ready;
    assign cfg_write = psel && penable && pwrite;
    assign out_free  = !r_out_v || o_res.ready;
    assign can_emit  = !r_pend_v || out_free;

    // newest minus window, borrow out means no floor
    assign diff    = {1'b0, r_newest} - {1'b0, TW'(r_window)};
    assign diff_ok = !diff[TW];

    assign reject    = r_floor_active && (r_in_item.time_stamp < r_floor);
    assign need_emit = reject || dup || full;
    assign rel_ok    = r_lim_ok && head.valid && (head.item.time_stamp <= r_lim);
    assign stored    = (cmd == twrb_pkg::CELL_INSERT) || (cmd == twrb_pkg::CELL_SHIFT);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            twrb_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = (i_req.operation == twrb_pkg::OP_FLUSH)
                        ? twrb_pkg::S_FLUSH : twrb_pkg::S_INSERT;
                end
            end
            twrb_pkg::S_INSERT: begin
                if (!need_emit || can_emit) begin
                    n_state = r_in_be ? twrb_pkg::S_RELEASE : twrb_pkg::S_FINISH;
                end
            end
            twrb_pkg::S_RELEASE: begin
                n_state = twrb_pkg::S_DRAIN;
            end
            twrb_pkg::S_DRAIN: begin
                if (!rel_ok) begin
                    n_state = twrb_pkg::S_FINISH;
                end
            end
            twrb_pkg::S_FLUSH: begin
                if (!head.valid) begin
                    n_state = twrb_pkg::S_FINISH;
                end
            end
            twrb_pkg::S_FINISH: begin
                if (!r_pend_v || out_free) begin
                    n_state = twrb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = twrb_pkg::S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        req_ready    = 1'b0;
        cmd          = twrb_pkg::CELL_HOLD;
        emit         = 1'b0;
        emit_verdict = twrb_pkg::VERDICT_ORDER;
        emit_item    = head.item;
        pend_to_last = 1'b0;
        case (r_state)
            twrb_pkg::S_IDLE: begin
                req_ready = 1'b1;
            end
            twrb_pkg::S_INSERT: begin
                if (!need_emit || can_emit) begin
                    if (reject) begin
                        emit         = 1'b1;
                        emit_verdict = twrb_pkg::VERDICT_REJECT;
                        emit_item    = r_in_item;
                    end else if (dup) begin
                        emit         = 1'b1;
                        emit_verdict = twrb_pkg::VERDICT_DUP;
                        emit_item    = r_in_item;
                    end else if (full && head.lt) begin
                        // new message is the oldest: pass it straight out
                        emit      = 1'b1;
                        emit_item = r_in_item;
                    end else if (full) begin
                        emit = 1'b1;
                        cmd  = twrb_pkg::CELL_SHIFT;
                    end else begin
                        cmd = twrb_pkg::CELL_INSERT;
                    end
                end
            end
            twrb_pkg::S_DRAIN: begin
                if (rel_ok && can_emit) begin
                    emit = 1'b1;
                    cmd  = twrb_pkg::CELL_POP;
                end
            end
            twrb_pkg::S_FLUSH: begin
                if (head.valid && can_emit) begin
                    emit = 1'b1;
                    cmd  = twrb_pkg::CELL_POP;
                end
            end
            twrb_pkg::S_FINISH: begin
                pend_to_last = r_pend_v && out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= twrb_pkg::S_IDLE;
            r_epoch        <= twrb_pkg::EPOCH_RESET;
            r_depth        <= twrb_pkg::DEPTH_RESET;
            r_window       <= twrb_pkg::WINDOW_W'(twrb_pkg::EPOCH_RESET)
                            * twrb_pkg::WINDOW_W'(twrb_pkg::DEPTH_RESET);
            r_in_batch     <= 1'b0;
            r_floor_active <= 1'b0;
            r_floor        <= '0;
            r_lim_ok       <= 1'b0;
            r_pend_v       <= 1'b0;
            r_out_v        <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_window <= twrb_pkg::WINDOW_W'(r_epoch) * twrb_pkg::WINDOW_W'(r_depth);

            if (cfg_write) begin
                case (paddr[2])
                    twrb_pkg::REG_EPOCH:  r_epoch <= pwdata[twrb_pkg::EPOCH_W-1:0];
                    twrb_pkg::REG_WINDOW: r_depth <= pwdata[twrb_pkg::DEPTH_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (accept) begin
                if (i_req.operation == twrb_pkg::OP_FLUSH) begin
                    r_in_batch     <= 1'b0;
                    r_floor_active <= 1'b0;
                end else if (!r_in_batch) begin
                    // fix the reject floor for this batch
                    r_in_batch     <= 1'b1;
                    r_floor_active <= !empty && diff_ok;
                    r_floor        <= diff[TW-1:0];
                end
            end

            if (r_state == twrb_pkg::S_RELEASE) begin
                r_lim_ok   <= !empty && diff_ok;
                r_in_batch <= 1'b0;
            end

            // output register refills from the hold stage, else drains
            if ((emit && r_pend_v) || pend_to_last) begin
                r_out_v <= 1'b1;
            end else if (o_res.valid && o_res.ready) begin
                r_out_v <= 1'b0;
            end

            if (emit) begin
                r_pend_v <= 1'b1;
            end else if (pend_to_last) begin
                r_pend_v <= 1'b0;
            end
        end

        // payload
        if (accept) begin
            r_in_item <= '{time_stamp:  i_req.time_stamp,
                           sort_key:    i_req.sort_key,
                           message_tag: i_req.message_tag};
            r_in_be   <= i_req.batch_end;
        end
        if (r_state == twrb_pkg::S_RELEASE) begin
            r_lim <= diff[TW-1:0];
        end
        if (stored && (empty || (r_in_item.time_stamp >= r_newest))) begin
            r_newest <= r_in_item.time_stamp;
        end
        if (emit) begin
            r_pend_verdict <= emit_verdict;
            r_pend_item    <= emit_item;
        end
        if ((emit && r_pend_v) || pend_to_last) begin
            r_out_verdict <= r_pend_verdict;
            r_out_item    <= r_pend_item;
            r_out_last    <= pend_to_last;
        end
    end

    assign i_req.ready       = req_ready;
    assign o_res.valid       = r_out_v;
    assign o_res.verdict     = r_out_verdict;
    assign o_res.out_time    = r_out_item.time_stamp;
    assign o_res.out_key     = r_out_item.sort_key;
    assign o_res.out_tag     = r_out_item.message_tag;
    assign o_res.last_result = r_out_last;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == twrb_pkg::REG_WINDOW)
        ? {{(twrb_pkg::DATA_W - twrb_pkg::DEPTH_W){1'b0}}, r_depth}
        : {{(twrb_pkg::DATA_W - twrb_pkg::EPOCH_W){1'b0}}, r_epoch};

endmodule

// ----- design/twrb_cell.sv -----
// ----------------------------------------------------------------------------
// twrb_cell
// One slot of the sorted chain: holds a message, compares it with the
// incoming one and moves data to or from its neighbors.
// ----------------------------------------------------------------------------
module twrb_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  twrb_pkg::t_cell_ctrl i_ctrl,
    input  twrb_pkg::t_link      i_left,
    input  twrb_pkg::t_link      i_right,
    output twrb_pkg::t_link      o_link,
    output logic                 o_eq
);

    logic            r_valid;
    twrb_pkg::t_item r_item;
    logic            n_valid;
    twrb_pkg::t_item n_item;
    logic            lt_self;

    // incoming message sorts ahead of this slot (an empty slot always loses)
    assign lt_self = !r_valid
        || (i_ctrl.item.time_stamp < r_item.time_stamp)
        || ((i_ctrl.item.time_stamp == r_item.time_stamp)
            && (i_ctrl.item.sort_key < r_item.sort_key));

    assign o_eq = r_valid
        && (i_ctrl.item.time_stamp == r_item.time_stamp)
        && (i_ctrl.item.sort_key == r_item.sort_key);

    assign o_link = '{valid: r_valid, lt: lt_self, item: r_item};

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        case (i_ctrl.cmd)
            twrb_pkg::CELL_INSERT: begin
                // open a gap at the insert point, push the tail up
                n_valid = r_valid | i_left.valid;
                if (lt_self && !i_left.lt) begin
                    n_item = i_ctrl.item;
                end else if (lt_self) begin
                    n_item = i_left.item;
                end
            end
            twrb_pkg::CELL_SHIFT: begin
                // full store: move the head part down, drop in the new one
                if (!i_right.lt) begin
                    n_item = i_right.item;
                end else if (!lt_self) begin
                    n_item = i_ctrl.item;
                end
            end
            twrb_pkg::CELL_POP: begin
                n_valid = i_right.valid;
                n_item  = i_right.item;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

endmodule
